// ===== rtl/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// shared constants and types of the receive ring deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

   localparam int RING_BYTES   = 8192;                // power of two
   localparam int OFS_W        = $clog2(RING_BYTES);
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 16;
   localparam int REL_W        = 13;
   localparam int RELEASE_BACK = 16;
   localparam int HDR_BYTES    = 4;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // one result beat as it travels from front to back
   typedef struct packed {
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic              frame_done;
      logic              frame_good;
      logic [LEN_W-1:0]  frame_length;
      logic [OFS_W-1:0]  next_offset;
   } rrd_token_type;

endpackage

`default_nettype wire

// ===== rtl/rrd_front.sv =====
// ----------------------------------------------------------------------------
// rrd_front
// header parse, payload and padding tracking, frame completion tokens
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [rrd_pkg::BYTE_W-1:0] ring_byte,
   output rrd_pkg::rrd_token_type          token,
   output logic                            token_valid
);
   import rrd_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_PAD     = 2'd2;

   localparam logic [1:0] HDR_STAT_LO = 2'd0;
   localparam logic [1:0] HDR_STAT_HI = 2'd1;
   localparam logic [1:0] HDR_LEN_LO  = 2'd2;
   localparam logic [1:0] HDR_LEN_HI  = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       hdr_idx_ff, hdr_idx_in;
   logic             good_ff, good_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [OFS_W-1:0] offset_ff, offset_in;

   logic [LEN_W-1:0] len_cur;
   logic [LEN_W-1:0] left_dec;
   logic [1:0]       pad;
   logic [OFS_W-1:0] next_offset;
   logic             hdr_last;

   assign hdr_last    = (phase_ff != PH_PAYLOAD) && (phase_ff != PH_PAD)
                        && (hdr_idx_ff == HDR_LEN_HI);
   assign len_cur     = hdr_last ? {ring_byte, length_ff[BYTE_W-1:0]} : length_ff;
   assign left_dec    = left_ff - LEN_W'(1);
   assign pad         = 2'(-(offset_ff[1:0] + len_cur[1:0]));
   assign next_offset = offset_ff + len_cur[OFS_W-1:0] + OFS_W'(HDR_BYTES) + OFS_W'(pad);

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      good_in    = good_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      offset_in  = offset_ff;

      token.data_valid   = 1'b0;
      token.data_byte    = ring_byte;
      token.last_byte    = 1'b0;
      token.frame_done   = 1'b0;
      token.frame_good   = good_ff;
      token.frame_length = len_cur;
      token.next_offset  = next_offset;

      case (phase_ff)
         PH_PAYLOAD: begin
            left_in          = left_dec;
            token.data_valid = good_ff;
            token.last_byte  = (left_dec == '0);
            if (left_dec == '0) begin
               if (pad == 2'd0) begin
                  token.frame_done = 1'b1;
                  phase_in         = PH_HEADER;
                  offset_in        = next_offset;
               end else begin
                  phase_in = PH_PAD;
                  left_in  = LEN_W'(pad);
               end
            end
         end
         PH_PAD: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               token.frame_done = 1'b1;
               phase_in         = PH_HEADER;
               offset_in        = next_offset;
            end
         end
         default: begin
            phase_in   = PH_HEADER;
            hdr_idx_in = hdr_idx_ff + 2'd1;
            case (hdr_idx_ff)
               HDR_STAT_LO: good_in = ring_byte[0];
               HDR_STAT_HI: good_in = good_ff;
               HDR_LEN_LO:  length_in = {length_ff[LEN_W-1:BYTE_W], ring_byte};
               default: begin
                  length_in = len_cur;
                  if (len_cur == '0) begin
                     left_in = '0;
                     if (pad == 2'd0) begin
                        token.frame_done = 1'b1;
                        offset_in        = next_offset;
                     end else begin
                        phase_in = PH_PAD;
                        left_in  = LEN_W'(pad);
                     end
                  end else begin
                     phase_in = PH_PAYLOAD;
                     left_in  = len_cur;
                  end
               end
            endcase
         end
      endcase
   end

   assign token_valid = take && (token.data_valid || token.frame_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= HDR_STAT_LO;
         good_ff    <= 1'b0;
         length_ff  <= '0;
         left_ff    <= '0;
         offset_ff  <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         good_ff    <= good_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         offset_ff  <= offset_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rrd_queue.sv =====
// ----------------------------------------------------------------------------
// rrd_queue
// short token queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire rrd_pkg::rrd_token_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output rrd_pkg::rrd_token_type      pop_data,
   output logic                        empty
);
   import rrd_pkg::*;

   rrd_token_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rrd_back.sv =====
// ----------------------------------------------------------------------------
// rrd_back
// result formatting: field qualification and release pointer
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_back (
   input  wire rrd_pkg::rrd_token_type     head,
   output logic                            data_valid,
   output logic [rrd_pkg::BYTE_W-1:0]      data_byte,
   output logic                            last_byte,
   output logic                            frame_done,
   output logic                            frame_good,
   output logic [rrd_pkg::LEN_W-1:0]       frame_length,
   output logic [rrd_pkg::REL_W-1:0]       release_pointer
);
   import rrd_pkg::*;

   logic [OFS_W-1:0] rel;

   // ring size is a power of two, so the wrap is the natural one
   assign rel = head.next_offset - OFS_W'(RELEASE_BACK);

   assign data_valid      = head.data_valid;
   assign data_byte       = head.data_valid ? head.data_byte : '0;
   assign last_byte       = head.data_valid && head.last_byte;
   assign frame_done      = head.frame_done;
   assign frame_good      = head.frame_done && head.frame_good;
   assign frame_length    = head.frame_done ? head.frame_length : '0;
   assign release_pointer = head.frame_done ? REL_W'(rel) : '0;

endmodule

`default_nettype wire

// ===== rtl/receive_ring_deframer.sv =====
// ----------------------------------------------------------------------------
// receive_ring_deframer
// splits receive ring bytes into frames, passes payload of good frames and
// reports frame completion with the release pointer
//
//   channel  direction  handshake      payload
//   req      in         push / full    req_ring_byte
//   rsp      out        pop / empty    rsp_data_valid .. rsp_release_pointer
//
// one ring byte per cycle while req_full is low; each result is written into the queue as its byte is taken
// the front parses and counts, a four-beat queue holds results for the back
// req_full rises only when the queue holds four unread results
// synchronous reset empties the queue and returns to the header of a frame
// at ring offset zero; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module receive_ring_deframer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [rrd_pkg::BYTE_W-1:0] req_ring_byte,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic                            rsp_data_valid,
   output logic [rrd_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic                            rsp_last_byte,
   output logic                            rsp_frame_done,
   output logic                            rsp_frame_good,
   output logic [rrd_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic [rrd_pkg::REL_W-1:0]       rsp_release_pointer
);
   import rrd_pkg::*;

   logic          take;
   rrd_token_type front_token;
   logic          front_valid;
   rrd_token_type head_token;

   assign take = req_push && !req_full;

   rrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .ring_byte   (req_ring_byte),
      .token       (front_token),
      .token_valid (front_valid)
   );

   rrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_token),
      .full      (req_full),
      .pop       (rsp_pop),
      .pop_data  (head_token),
      .empty     (rsp_empty)
   );

   rrd_back u_back (
      .head            (head_token),
      .data_valid      (rsp_data_valid),
      .data_byte       (rsp_data_byte),
      .last_byte       (rsp_last_byte),
      .frame_done      (rsp_frame_done),
      .frame_good      (rsp_frame_good),
      .frame_length    (rsp_frame_length),
      .release_pointer (rsp_release_pointer)
   );

   a_empty_fall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(take))
      else $error("result appeared without an accepted byte");

   a_no_blank_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data_valid || rsp_frame_done))
      else $error("queued result carries neither data nor completion");

   a_release_aligned: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> (rsp_release_pointer[1:0] == 2'd0))
      else $error("release pointer off a 4-byte boundary");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(req_full && rsp_empty))
      else $error("queue full and empty together");

endmodule

`default_nettype wire
